FILE: rtl/bvrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvrs_pkg: shared types for the bit vector rank/select block
// Command codes, field widths and the request/result structs.
// ----------------------------------------------------------------------------
package bvrs_pkg;

    localparam int CNT_W  = 11;
    localparam int POS_W  = 10;
    localparam int IDX_W  = 7;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_RANK   = 2'd1,
        CMD_SELECT = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic [CNT_W-1:0]  range_start;
        logic [CNT_W-1:0]  range_end;
        logic [CNT_W-1:0]  occurrence;
        logic              target_bit;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] bit_count;
        logic [POS_W-1:0] bit_position;
        logic             found;
    } rsp_t;

endpackage

FILE: rtl/bvrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvrs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bvrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bitvector_rank_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitvector_rank_select: byte-loaded bit vector with range rank and select
// Load, no-op, empty-range, k = 0 select: result in the cycle after acceptance.
// Rank/select: one stored byte per cycle through a single popcount/scan unit,
// busy from acceptance until the result strobe.
// Select stops early at the byte holding the k-th match. Results cannot stall.
// Reset clears the length register and sequencer; store contents stay undefined.
// ----------------------------------------------------------------------------
module bitvector_rank_select #(
    parameter int MAX_BYTES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bvrs_pkg::req_t                request,
    output logic                          done,
    output bvrs_pkg::rsp_t                result,
    input  logic                          cfg_we,
    input  logic [bvrs_pkg::CNT_W-1:0]    cfg_wdata
);

    localparam int AW      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CAP     = MAX_BYTES * 8;
    localparam int CAP_MAX = (1 << bvrs_pkg::CNT_W) - 1;
    localparam logic [bvrs_pkg::CNT_W-1:0] CAP_L =
        bvrs_pkg::CNT_W'((CAP > CAP_MAX) ? CAP_MAX : CAP);
    localparam int BN_W = bvrs_pkg::CNT_W - 3;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                       state_reg, state_next;
    logic [bvrs_pkg::CNT_W-1:0]   vlen_reg;
    logic                         sel_reg, sel_next;
    logic                         tbit_reg, tbit_next;
    logic [bvrs_pkg::CNT_W-1:0]   lo_reg, lo_next;
    logic [bvrs_pkg::CNT_W-1:0]   hi_reg, hi_next;
    logic [bvrs_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [BN_W-1:0]              issue_reg, issue_next;
    logic [BN_W-1:0]              last_reg, last_next;
    logic [BN_W-1:0]              dbyte_reg, dbyte_next;
    logic                         dvld_reg, dvld_next;
    logic [bvrs_pkg::CNT_W-1:0]   acc_reg, acc_next;
    logic                         done_reg, done_next;
    bvrs_pkg::rsp_t               rsp_reg, rsp_next;

    logic                         accept;
    logic                         ram_we;
    logic [7:0]                   rdata;
    logic [bvrs_pkg::CNT_W-1:0]   eff_len;
    logic [bvrs_pkg::CNT_W-1:0]   end_c;
    logic [bvrs_pkg::CNT_W-1:0]   end_m1;
    logic [7:0]                   hit;
    logic [3:0]                   pc;
    logic [bvrs_pkg::CNT_W:0]     sum;
    logic                         hit_k;
    logic [3:0]                   need;
    logic [2:0]                   sel_idx;
    logic [3:0]                   run_cnt;
    logic [bvrs_pkg::CNT_W-1:0]   bit_pos;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;
    assign ram_we = accept && (request.cmd == bvrs_pkg::CMD_LOAD)
                    && (32'(request.byte_index) < MAX_BYTES);

    bvrs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(request.byte_index)),
        .wdata (request.byte_value),
        .raddr (AW'(issue_reg)),
        .rdata (rdata)
    );

    assign eff_len = (vlen_reg > CAP_L) ? CAP_L : vlen_reg;
    assign end_c   = (request.range_end > eff_len) ? eff_len : request.range_end;
    assign end_m1  = end_c - bvrs_pkg::CNT_W'(1);

    // per-byte evaluation: range mask, match, popcount, k-th match scan
    always_comb
    begin
        logic [bvrs_pkg::CNT_W-1:0] p;
        pc      = '0;
        run_cnt = '0;
        sel_idx = '0;
        for (int i = 0; i < 8; i++)
        begin
            p = {dbyte_reg, 3'(i)};
            hit[i] = (p >= lo_reg) && (p < hi_reg) && (rdata[i] == tbit_reg);
            pc = pc + {3'b0, hit[i]};
        end
        sum   = {1'b0, acc_reg} + {{(bvrs_pkg::CNT_W - 3){1'b0}}, pc};
        hit_k = (sum >= {1'b0, k_reg});
        need  = 4'(k_reg - acc_reg);
        for (int i = 0; i < 8; i++)
        begin
            if (hit[i])
            begin
                run_cnt = run_cnt + 4'd1;
                if (run_cnt == need)
                begin
                    sel_idx = 3'(i);
                end
            end
        end
        bit_pos = {dbyte_reg, sel_idx};
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        tbit_next  = tbit_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        issue_next = issue_reg;
        last_next  = last_reg;
        dbyte_next = dbyte_reg;
        dvld_next  = dvld_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        rsp_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.cmd)
                        bvrs_pkg::CMD_RANK, bvrs_pkg::CMD_SELECT:
                        begin
                            if ((request.range_start >= end_c) ||
                                ((request.cmd == bvrs_pkg::CMD_SELECT) &&
                                 (request.occurrence == '0)))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                                sel_next   = (request.cmd == bvrs_pkg::CMD_SELECT);
                                tbit_next  = request.target_bit;
                                lo_next    = request.range_start;
                                hi_next    = end_c;
                                k_next     = request.occurrence;
                                issue_next = request.range_start[bvrs_pkg::CNT_W-1:3];
                                last_next  = end_m1[bvrs_pkg::CNT_W-1:3];
                                dvld_next  = 1'b0;
                                acc_next   = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                issue_next = issue_reg + BN_W'(1);
                dbyte_next = issue_reg;
                dvld_next  = 1'b1;
                if (dvld_reg)
                begin
                    acc_next = sum[bvrs_pkg::CNT_W-1:0];
                    if (sel_reg && hit_k)
                    begin
                        state_next            = ST_IDLE;
                        done_next             = 1'b1;
                        rsp_next.found        = 1'b1;
                        rsp_next.bit_position = bit_pos[bvrs_pkg::POS_W-1:0];
                    end
                    else if (dbyte_reg == last_reg)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                        if (!sel_reg)
                        begin
                            rsp_next.bit_count = sum[bvrs_pkg::CNT_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vlen_reg  <= '0;
            dvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
            sel_reg   <= 1'b0;
            tbit_reg  <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            k_reg     <= '0;
            issue_reg <= '0;
            last_reg  <= '0;
            dbyte_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                vlen_reg <= cfg_wdata;
            end
            dvld_reg  <= dvld_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
            sel_reg   <= sel_next;
            tbit_reg  <= tbit_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            k_reg     <= k_next;
            issue_reg <= issue_next;
            last_reg  <= last_next;
            dbyte_reg <= dbyte_next;
            acc_reg   <= acc_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result issued while sequencer running");

    a_found_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_reg.found |-> (done_reg && (rsp_reg.bit_count == '0)))
        else $error("found flag without select result");

    a_byte_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && dvld_reg) |-> (dbyte_reg <= last_reg))
        else $error("scan passed last byte of range");

    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && $past(state_reg == ST_IDLE)) |-> !done_reg)
        else $error("result strobe on query start");

endmodule

FILE: tb/bvrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvrs_checker: result predictor and scoreboard for bitvector_rank_select
// Follows the request, result and length-register ports. It keeps its own
// copy of the byte store and the length register. For each accepted request
// it computes the expected rank/select answer and queues it. Each strobed
// result is checked field by field against the oldest queued answer.
// ----------------------------------------------------------------------------
module bvrs_checker
    import bvrs_pkg::*;
#(
    parameter int MAX_BYTES = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  req_t             request,
    input  logic             done,
    input  rsp_t             result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);

    // keep the log short when the design is badly broken
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        cmd_t cmd;
        rsp_t rsp;
    } answer_t;

    logic [BYTE_W-1:0] store_bytes [MAX_BYTES];
    logic [CNT_W-1:0]  length_bits;
    answer_t           answers_q [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic report(input string msg);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic rsp_t expected_answer(input req_t rq);
        rsp_t a;
        int   eff;
        int   stop;
        int   p;
        int   hits;
        a    = '0;
        hits = 0;
        eff  = (int'(length_bits) > MAX_BYTES * 8) ? MAX_BYTES * 8 : int'(length_bits);
        stop = (int'(rq.range_end) > eff) ? eff : int'(rq.range_end);
        case (rq.cmd)
            CMD_RANK:
            begin
                for (p = int'(rq.range_start); p < stop; p++)
                begin
                    if (store_bytes[p / 8][p % 8] == rq.target_bit)
                    begin
                        hits++;
                    end
                end
                a.bit_count = hits[CNT_W-1:0];
            end
            CMD_SELECT:
            begin
                for (p = int'(rq.range_start); p < stop; p++)
                begin
                    if (store_bytes[p / 8][p % 8] == rq.target_bit)
                    begin
                        hits++;
                        if (hits == int'(rq.occurrence))
                        begin
                            a.bit_position = p[POS_W-1:0];
                            a.found        = 1'b1;
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t head;
        answer_t fresh;
        if (!rst_n)
        begin
            answers_q.delete();
            length_bits = '0;
            pending <= 0;
        end
        else
        begin
            // results first: one accepted on this edge belongs to an older request
            if (done)
            begin
                if (answers_q.size() == 0)
                begin
                    report($sformatf("result with nothing outstanding: count %0d pos %0d found %0b",
                                     result.bit_count, result.bit_position, result.found));
                end
                else
                begin
                    head = answers_q.pop_front();
                    if (result.bit_count !== head.rsp.bit_count)
                    begin
                        report($sformatf("cmd %0d bit_count got %0d expected %0d", head.cmd,
                                         result.bit_count, head.rsp.bit_count));
                    end
                    if (result.bit_position !== head.rsp.bit_position)
                    begin
                        report($sformatf("cmd %0d bit_position got %0d expected %0d", head.cmd,
                                         result.bit_position, head.rsp.bit_position));
                    end
                    if (result.found !== head.rsp.found)
                    begin
                        report($sformatf("cmd %0d found got %0b expected %0b", head.cmd,
                                         result.found, head.rsp.found));
                    end
                end
            end
            if (cfg_we)
            begin
                length_bits = cfg_wdata;
            end
            if (start && !busy)
            begin
                fresh.cmd = request.cmd;
                fresh.rsp = expected_answer(request);
                answers_q.push_back(fresh);
                if (request.cmd == CMD_LOAD && int'(request.byte_index) < MAX_BYTES)
                begin
                    store_bytes[request.byte_index] = request.byte_value;
                end
            end
            pending <= answers_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for bitvector_rank_select
// Fills the whole byte store, runs directed corner requests, then random
// load/rank/select/unused requests over several vector lengths, extremes
// included. Sender gaps are random bursts; the final phase runs back to back.
// Checking is done by bvrs_checker.
// ----------------------------------------------------------------------------
module testbench;

    import bvrs_pkg::*;

    localparam int   STORE_BYTES     = 128;
    localparam int   STORE_BITS      = STORE_BYTES * 8;
    localparam int   CNT_MAX         = (1 << CNT_W) - 1;
    localparam int   CYCLE_LIMIT     = 1_000_000;
    localparam int   DRAIN_CYCLES    = STORE_BYTES + 4;
    localparam int   PHASES          = 10;
    localparam int   ITEMS_PER_PHASE = 145;
    localparam cmd_t CMD_UNUSED      = cmd_t'(2'd3);

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             request;
    logic             done;
    rsp_t             result;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycles  = 0;
    int cur_len = 0;

    bitvector_rank_select #(
        .MAX_BYTES (STORE_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bvrs_checker #(
        .MAX_BYTES (STORE_BYTES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(input req_t rq);
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic sender_gap(input bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_outstanding();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_length(input int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CNT_W-1:0];
        cur_len    = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic req_t load_req(input int idx, input int val);
        req_t r;
        r            = '0;
        r.cmd        = CMD_LOAD;
        r.byte_index = idx[IDX_W-1:0];
        r.byte_value = val[BYTE_W-1:0];
        return r;
    endfunction

    function automatic req_t query_req(input cmd_t c, input int s, input int e,
                                       input int k, input bit t);
        req_t r;
        r             = '0;
        r.cmd         = c;
        r.range_start = s[CNT_W-1:0];
        r.range_end   = e[CNT_W-1:0];
        r.occurrence  = k[CNT_W-1:0];
        r.target_bit  = t;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   roll;
        int   eff;
        int   s;
        int   e;
        int   span;
        eff          = (cur_len > STORE_BITS) ? STORE_BITS : cur_len;
        roll         = $urandom_range(0, 99);
        r.byte_index = $urandom_range(0, STORE_BYTES - 1);
        r.byte_value = $urandom_range(0, 255);
        r.target_bit = $urandom_range(0, 1);
        r.range_start = $urandom_range(0, CNT_MAX);
        r.range_end   = $urandom_range(0, CNT_MAX);
        r.occurrence  = $urandom_range(0, CNT_MAX);
        if (roll < 20)
        begin
            r.cmd = CMD_LOAD;
        end
        else if (roll < 24)
        begin
            r.cmd = CMD_UNUSED;
        end
        else
        begin
            r.cmd = ($urandom_range(0, 1) == 1) ? CMD_RANK : CMD_SELECT;
            s = ($urandom_range(0, 9) < 8) ? $urandom_range(0, eff) : $urandom_range(0, CNT_MAX);
            case ($urandom_range(0, 9))
                6, 7:    e = $urandom_range(0, CNT_MAX);
                8:       e = eff;
                9:       e = CNT_MAX;
                default: e = s + $urandom_range(0, 300);
            endcase
            if (e > CNT_MAX)
            begin
                e = CNT_MAX;
            end
            span = ((e < eff) ? e : eff) - s;
            if (span < 0)
            begin
                span = 0;
            end
            r.range_start = s[CNT_W-1:0];
            r.range_end   = e[CNT_W-1:0];
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                r.occurrence = $urandom_range(1, span + 1);
            end
            else if (roll == 7)
            begin
                r.occurrence = '0;
            end
        end
        return r;
    endfunction

    initial
    begin : stimulus
        req_t directed_q [$];
        int   phase_len [PHASES];
        int   ph;
        int   n;
        int   i;
        int   val;

        start     <= 1'b0;
        request   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_length(STORE_BITS);

        // write every byte before any query can read it
        for (i = 0; i < STORE_BYTES; i++)
        begin
            val = $urandom_range(0, 255);
            if (i == 0)
                val = 8'h00;
            else if (i == 1)
                val = 8'hA5;
            else if (i == STORE_BYTES - 1)
                val = 8'hFF;
            send(load_req(i, val));
            sender_gap(1'b1);
        end

        directed_q.push_back(query_req(CMD_RANK, 0, STORE_BITS, 0, 1'b1));
        directed_q.push_back(query_req(CMD_RANK, 0, STORE_BITS, 0, 1'b0));
        directed_q.push_back(query_req(CMD_SELECT, 0, STORE_BITS, 1, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, 0, STORE_BITS, 1, 1'b0));
        directed_q.push_back(query_req(CMD_SELECT, 0, STORE_BITS, 0, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, 0, STORE_BITS, CNT_MAX, 1'b0));
        directed_q.push_back(query_req(CMD_RANK, 500, 500, 0, 1'b1));
        directed_q.push_back(query_req(CMD_RANK, 900, 100, 0, 1'b0));
        directed_q.push_back(query_req(CMD_RANK, 0, CNT_MAX, 0, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, CNT_MAX, CNT_MAX, 1, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, STORE_BITS - 8, STORE_BITS, 8, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, STORE_BITS - 1, CNT_MAX, 1, 1'b1));
        directed_q.push_back(query_req(CMD_RANK, STORE_BITS - 1, STORE_BITS, 0, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, 8, 16, 4, 1'b1));
        directed_q.push_back(query_req(CMD_SELECT, 8, 16, 5, 1'b1));
        directed_q.push_back('1);
        directed_q.push_back(load_req(0, 8'hFF));
        directed_q.push_back(query_req(CMD_SELECT, 0, 16, 1, 1'b0));
        directed_q.push_back(load_req(STORE_BYTES - 1, 8'h00));
        directed_q.push_back(query_req(CMD_RANK, STORE_BITS - 8, STORE_BITS, 0, 1'b0));
        foreach (directed_q[j])
        begin
            send(directed_q[j]);
            sender_gap(1'b1);
        end

        phase_len = '{CNT_MAX, 37, 0, 1, STORE_BITS - 1, 600, 8, 0, STORE_BITS, STORE_BITS};
        phase_len[7] = $urandom_range(0, CNT_MAX);

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_outstanding();
            repeat (4) @(posedge clk);
            write_length(phase_len[ph]);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send(random_req());
                if (ph == 4 && n == 70)
                    drain_outstanding();
                else
                    sender_gap(ph != PHASES - 1);
            end
        end

        drain_outstanding();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bvrs_pkg.sv
rtl/bvrs_ram.sv
rtl/bitvector_rank_select.sv
tb/bvrs_checker.sv
tb/testbench.sv
